// ----- rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator package
// Operation codes, status codes and frame tag encodings shared by the design.
// ----------------------------------------------------------------------------
package bfa_pkg;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_BUILD   = 2'd1,
		OP_ALLOC   = 2'd2,
		OP_FREE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WRONG_PHASE = 3'd1,
		ST_RANGE       = 3'd2,
		ST_NO_BLOCK    = 3'd3,
		ST_NOT_ALLOC   = 3'd4
	} status_t;

	// Frame tags: values below the order count mark a free block head of
	// that order, the rest are the special marks below.
	localparam int TAG_W = 5;
	localparam logic [TAG_W-1:0] TAG_FREE0     = 5'd0;
	localparam logic [TAG_W-1:0] TAG_RESERVED  = 5'd16;
	localparam logic [TAG_W-1:0] TAG_ALLOCATED = 5'd17;
	localparam logic [TAG_W-1:0] TAG_GROUPED   = 5'd18;

endpackage

// ----- rtl/buddy_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator
// Reserve, build, allocate and free over a buddy system of frames, with the
// frame tags and list links held in synchronous memories.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on status and frame for a single cycle with done high, and the
// receiver cannot stall it. After reset the block runs a clearing pass over
// every frame of the tag memory, during which busy stays high. All work is
// carried out by one sequencer around a tag memory and a pair of link
// memories, each with a registered read, so the cost of a request is set by
// the number of memory accesses it needs. Phase and range errors are
// answered straight from the idle state. A reserve writes the reserved mark
// into each frame of the range in turn. Build makes one merge pass per
// order over the aligned candidate frames, then a fill pass over every
// frame that puts each free block head on its list. Allocate scans the
// list heads one order per cycle, then unlinks the block it finds and
// splits it down one level at a time. Free walks the grouped marks one
// level at a time, then repeats a merge for each level it climbs, up to
// ORDERS - 1 levels.
module buddy_frame_allocator #(
	parameter int FRAMES = 1024,
	parameter int ORDERS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] first_frame,
	input  logic [15:0] last_frame,
	input  logic [3:0]  order,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] frame
);

	localparam int AW  = $clog2(FRAMES);
	localparam int LW  = AW + 1;
	localparam int OIW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
	localparam int TW  = bfa_pkg::TAG_W;

	// The empty list marker is the frame count itself, one past the last frame.
	localparam logic [LW-1:0] NIL       = LW'(FRAMES);
	localparam logic [16:0]   FRAMES_17 = 17'(FRAMES);
	localparam logic [TW-1:0] ORD_N     = TW'(ORDERS);
	localparam logic [TW-1:0] ORD_TOP   = TW'(ORDERS - 1);
	localparam logic [TW-1:0] AW_T      = TW'(AW);

	typedef enum logic [25:0] {
		S_CLR     = 26'd1,
		S_IDLE    = 26'd2,
		S_RSV     = 26'd4,
		S_BM_CHK  = 26'd8,
		S_BM_NEXT = 26'd16,
		S_M0      = 26'd32,
		S_M1      = 26'd64,
		S_M2      = 26'd128,
		S_M3      = 26'd256,
		S_M4      = 26'd512,
		S_M5      = 26'd1024,
		S_U0      = 26'd2048,
		S_U1      = 26'd4096,
		S_A0      = 26'd8192,
		S_A1      = 26'd16384,
		S_BF0     = 26'd32768,
		S_BF1     = 26'd65536,
		S_BF2     = 26'd131072,
		S_AS      = 26'd262144,
		S_AT      = 26'd524288,
		S_AD      = 26'd1048576,
		S_FR1     = 26'd2097152,
		S_FC      = 26'd4194304,
		S_FW      = 26'd8388608,
		S_FT      = 26'd16777216,
		S_FM      = 26'd33554432
	} state_t;

	state_t state_q, ret_q;

	logic [LW-1:0] cnt_q;
	logic [TW-1:0] o_q, k_q, t_q, l_ord_q;
	logic [3:0]    ord_q;
	logic [AW-1:0] x_q, y_q, lo_q, hi_q, l_x_q, f_q, last_q;
	logic [LW-1:0] b_q, tl_q;
	logic          lk_q, built_q;
	logic [LW-1:0] head_q [ORDERS];
	logic [LW-1:0] tail_q [ORDERS];
	logic          done_q;
	logic [2:0]    status_q;
	logic [15:0]   frame_q;

	// Memories and their ports.
	logic [TW-1:0] tag_mem [FRAMES];
	logic [LW-1:0] nxt_mem [FRAMES];
	logic [LW-1:0] prv_mem [FRAMES];

	logic          tag_we, tag_re, lnk_re, nxt_we, prv_we;
	logic [AW-1:0] tag_wa, tag_ra, lnk_ra, nxt_wa, prv_wa;
	logic [TW-1:0] tag_wd, tag_rd;
	logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

	// Buddy addresses used by the merge step, the split step and the free walk.
	logic [LW-1:0] mb, ab, fb;
	logic [TW-1:0] o_dec;
	logic [OIW-1:0] l_idx, o_idx;

	assign mb    = {1'b0, x_q} ^ (LW'(1) << tag_rd);
	assign o_dec = o_q - TW'(1);
	assign ab    = {1'b0, x_q} ^ (LW'(1) << o_dec);
	assign fb    = {1'b0, y_q} ^ (LW'(1) << k_q);
	assign l_idx = l_ord_q[OIW-1:0];
	assign o_idx = o_q[OIW-1:0];

	always_comb begin
		tag_we = 1'b0;
		tag_wa = cnt_q[AW-1:0];
		tag_wd = bfa_pkg::TAG_FREE0;
		tag_re = 1'b0;
		tag_ra = x_q;
		lnk_re = 1'b0;
		lnk_ra = l_x_q;
		nxt_we = 1'b0;
		nxt_wa = l_x_q;
		nxt_wd = NIL;
		prv_we = 1'b0;
		prv_wa = l_x_q;
		prv_wd = NIL;
		unique case (state_q)
			S_CLR: begin
				tag_we = 1'b1;
			end
			S_IDLE: begin
				tag_re = 1'b1;
				tag_ra = first_frame[AW-1:0];
			end
			S_RSV: begin
				tag_we = 1'b1;
				tag_wd = bfa_pkg::TAG_RESERVED;
			end
			S_M0: begin
				tag_re = 1'b1;
			end
			S_M1: begin
				tag_re = 1'b1;
				tag_ra = mb[AW-1:0];
			end
			S_M2: begin
				tag_we = (tag_rd == t_q);
				tag_wa = (b_q[AW-1:0] < x_q) ? b_q[AW-1:0] : x_q;
				tag_wd = t_q + TW'(1);
			end
			S_M3: begin
				tag_we = 1'b1;
				tag_wa = hi_q;
				tag_wd = bfa_pkg::TAG_GROUPED;
			end
			S_U0: begin
				lnk_re = 1'b1;
			end
			S_U1: begin
				nxt_we = (prv_rd != NIL);
				nxt_wa = prv_rd[AW-1:0];
				nxt_wd = nxt_rd;
				prv_we = (nxt_rd != NIL);
				prv_wa = nxt_rd[AW-1:0];
				prv_wd = prv_rd;
			end
			S_A0: begin
				prv_we = 1'b1;
				prv_wd = tail_q[l_idx];
				nxt_we = 1'b1;
			end
			S_A1: begin
				nxt_we = (tl_q != NIL);
				nxt_wa = tl_q[AW-1:0];
				nxt_wd = {1'b0, l_x_q};
			end
			S_BF0: begin
				tag_re = 1'b1;
				tag_ra = cnt_q[AW-1:0];
			end
			S_AT: begin
				tag_we = 1'b1;
				tag_wa = x_q;
				tag_wd = bfa_pkg::TAG_ALLOCATED;
			end
			S_AD: begin
				tag_we = (o_q != {1'b0, ord_q}) && (ab < NIL);
				tag_wa = ab[AW-1:0];
				tag_wd = o_dec;
			end
			S_FC: begin
				tag_re = 1'b1;
				tag_ra = fb[AW-1:0];
			end
			S_FT: begin
				tag_we = 1'b1;
				tag_wa = f_q;
				tag_wd = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (tag_re) begin
			tag_rd <= tag_mem[tag_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		if (prv_we) begin
			prv_mem[prv_wa] <= prv_wd;
		end
		if (lnk_re) begin
			nxt_rd <= nxt_mem[lnk_ra];
			prv_rd <= prv_mem[lnk_ra];
		end
	end

	logic fr_oob, lr_oob;
	assign fr_oob = {1'b0, first_frame} >= FRAMES_17;
	assign lr_oob = {1'b0, last_frame} >= FRAMES_17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ret_q    <= S_IDLE;
			cnt_q    <= '0;
			o_q      <= '0;
			k_q      <= '0;
			t_q      <= '0;
			l_ord_q  <= '0;
			ord_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			l_x_q    <= '0;
			f_q      <= '0;
			last_q   <= '0;
			b_q      <= '0;
			tl_q     <= '0;
			lk_q     <= 1'b0;
			built_q  <= 1'b0;
			done_q   <= 1'b0;
			status_q <= bfa_pkg::ST_OK;
			frame_q  <= '0;
			for (int i = 0; i < ORDERS; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + LW'(1);
					if (cnt_q == LW'(FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						ord_q   <= order;
						f_q     <= first_frame[AW-1:0];
						last_q  <= last_frame[AW-1:0];
						frame_q <= '0;
						case (op)
							bfa_pkg::OP_RESERVE: begin
								if (built_q) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_WRONG_PHASE;
								end else if (fr_oob || lr_oob) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_RANGE;
								end else if (first_frame > last_frame) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_OK;
								end else begin
									cnt_q   <= {1'b0, first_frame[AW-1:0]};
									state_q <= S_RSV;
								end
							end
							bfa_pkg::OP_BUILD: begin
								if (built_q) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_WRONG_PHASE;
								end else begin
									o_q     <= '0;
									cnt_q   <= '0;
									state_q <= S_BM_CHK;
								end
							end
							bfa_pkg::OP_ALLOC: begin
								if (!built_q) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_WRONG_PHASE;
								end else if ({1'b0, order} >= ORD_N) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_RANGE;
								end else begin
									o_q     <= {1'b0, order};
									state_q <= S_AS;
								end
							end
							default: begin
								if (!built_q) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_WRONG_PHASE;
								end else if (fr_oob) begin
									done_q   <= 1'b1;
									status_q <= bfa_pkg::ST_RANGE;
								end else begin
									state_q <= S_FR1;
								end
							end
						endcase
					end
				end
				S_RSV: begin
					if (cnt_q[AW-1:0] == last_q) begin
						done_q   <= 1'b1;
						status_q <= bfa_pkg::ST_OK;
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				S_BM_CHK: begin
					if (cnt_q >= NIL) begin
						cnt_q <= '0;
						if (o_q == ORD_TOP) begin
							state_q <= S_BF0;
						end else begin
							o_q <= o_q + TW'(1);
						end
					end else begin
						x_q     <= cnt_q[AW-1:0];
						lk_q    <= 1'b0;
						state_q <= S_M0;
					end
				end
				S_BM_NEXT: begin
					// Past the top address bit only frame zero is a candidate.
					if (o_q >= AW_T) begin
						cnt_q <= NIL;
					end else begin
						cnt_q <= cnt_q + (LW'(2) << o_q);
					end
					state_q <= S_BM_CHK;
				end
				S_M0: begin
					state_q <= S_M1;
				end
				S_M1: begin
					if (tag_rd >= ORD_TOP || mb >= NIL) begin
						if (lk_q) begin
							done_q   <= 1'b1;
							status_q <= bfa_pkg::ST_OK;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_BM_NEXT;
						end
					end else begin
						t_q     <= tag_rd;
						b_q     <= mb;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (tag_rd != t_q) begin
						if (lk_q) begin
							done_q   <= 1'b1;
							status_q <= bfa_pkg::ST_OK;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_BM_NEXT;
						end
					end else begin
						lo_q    <= (b_q[AW-1:0] < x_q) ? b_q[AW-1:0] : x_q;
						hi_q    <= (b_q[AW-1:0] < x_q) ? x_q : b_q[AW-1:0];
						state_q <= S_M3;
					end
				end
				S_M3: begin
					x_q <= lo_q;
					if (lk_q) begin
						l_ord_q <= t_q;
						l_x_q   <= lo_q;
						ret_q   <= S_M4;
						state_q <= S_U0;
					end else begin
						state_q <= S_BM_NEXT;
					end
				end
				S_M4: begin
					l_ord_q <= t_q;
					l_x_q   <= hi_q;
					ret_q   <= S_M5;
					state_q <= S_U0;
				end
				S_M5: begin
					l_ord_q <= t_q + TW'(1);
					l_x_q   <= lo_q;
					ret_q   <= S_M0;
					state_q <= S_A0;
				end
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					if (prv_rd == NIL) begin
						head_q[l_idx] <= nxt_rd;
					end
					if (nxt_rd == NIL) begin
						tail_q[l_idx] <= prv_rd;
					end
					state_q <= ret_q;
				end
				S_A0: begin
					tl_q          <= tail_q[l_idx];
					tail_q[l_idx] <= {1'b0, l_x_q};
					if (tail_q[l_idx] == NIL) begin
						head_q[l_idx] <= {1'b0, l_x_q};
					end
					state_q <= S_A1;
				end
				S_A1: begin
					state_q <= ret_q;
				end
				S_BF0: begin
					if (cnt_q == NIL) begin
						built_q  <= 1'b1;
						done_q   <= 1'b1;
						status_q <= bfa_pkg::ST_OK;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_BF1;
					end
				end
				S_BF1: begin
					if (tag_rd < ORD_N) begin
						l_ord_q <= tag_rd;
						l_x_q   <= cnt_q[AW-1:0];
						ret_q   <= S_BF2;
						state_q <= S_A0;
					end else begin
						state_q <= S_BF2;
					end
				end
				S_BF2: begin
					cnt_q   <= cnt_q + LW'(1);
					state_q <= S_BF0;
				end
				S_AS: begin
					if (o_q == ORD_N) begin
						done_q   <= 1'b1;
						status_q <= bfa_pkg::ST_NO_BLOCK;
						state_q  <= S_IDLE;
					end else if (head_q[o_idx] == NIL) begin
						o_q <= o_q + TW'(1);
					end else begin
						x_q     <= head_q[o_idx][AW-1:0];
						l_ord_q <= o_q;
						l_x_q   <= head_q[o_idx][AW-1:0];
						ret_q   <= S_AT;
						state_q <= S_U0;
					end
				end
				S_AT: begin
					state_q <= S_AD;
				end
				S_AD: begin
					// Each split hands the upper half to the next lower list.
					if (o_q == {1'b0, ord_q}) begin
						done_q   <= 1'b1;
						status_q <= bfa_pkg::ST_OK;
						frame_q  <= 16'(x_q);
						state_q  <= S_IDLE;
					end else begin
						o_q <= o_dec;
						if (ab < NIL) begin
							l_ord_q <= o_dec;
							l_x_q   <= ab[AW-1:0];
							ret_q   <= S_AD;
							state_q <= S_A0;
						end
					end
				end
				S_FR1: begin
					if (tag_rd != bfa_pkg::TAG_ALLOCATED) begin
						done_q   <= 1'b1;
						status_q <= bfa_pkg::ST_NOT_ALLOC;
						state_q  <= S_IDLE;
					end else begin
						y_q     <= f_q;
						k_q     <= '0;
						state_q <= S_FC;
					end
				end
				S_FC: begin
					b_q <= fb;
					if (k_q < ORD_TOP && fb < NIL) begin
						state_q <= S_FW;
					end else begin
						state_q <= S_FT;
					end
				end
				S_FW: begin
					if (tag_rd == bfa_pkg::TAG_GROUPED) begin
						y_q     <= (b_q[AW-1:0] < y_q) ? b_q[AW-1:0] : y_q;
						k_q     <= k_q + TW'(1);
						state_q <= S_FC;
					end else begin
						state_q <= S_FT;
					end
				end
				S_FT: begin
					l_ord_q <= k_q;
					l_x_q   <= f_q;
					ret_q   <= S_FM;
					state_q <= S_A0;
				end
				S_FM: begin
					x_q     <= f_q;
					lk_q    <= 1'b1;
					state_q <= S_M0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign frame  = frame_q;

	// Once built, the allocator never returns to the reserve phase.
	a_built_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(built_q))
		else $error("built flag dropped");

	// Reserving frames is only possible before build.
	a_rsv_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RSV) |-> !built_q)
		else $error("reserve running after build");

	// Both ends of the order zero list are empty together.
	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q[0] == NIL) == (tail_q[0] == NIL))
		else $error("list head and tail disagree");

	// Only a successful request carries a frame index.
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != bfa_pkg::ST_OK)) |-> (frame_q == '0))
		else $error("frame set on an error result");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy frame allocator testbench
// Sends reserve, build, allocate and free requests with random gaps between
// them. A built-in buddy model predicts status and frame for every accepted
// request, and each strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int FR  = 1024;
	localparam int ORD = 11;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [15:0] first_frame;
	logic [15:0] last_frame;
	logic [3:0]  order;
	logic        done;
	logic [2:0]  status;
	logic [15:0] frame;

	int idle_pct;

	typedef struct {
		bfa_pkg::status_t st;
		logic [15:0]      fr;
	} outcome_t;

	// Buddy model with its own copy of the tags, links and list ends. It also
	// keeps the heads handed out so far, so that stimulus can free them.
	class alloc_scoreboard;
		bit [4:0]    tag[FR];
		int          nxt[FR];
		int          prv[FR];
		int          head[ORD];
		int          tail[ORD];
		bit          built;
		outcome_t    pending[$];
		logic [15:0] live[$];
		int          errors;

		function new();
			foreach (tag[i]) begin
				tag[i] = bfa_pkg::TAG_FREE0;
				nxt[i] = 0;
				prv[i] = 0;
			end
			foreach (head[i]) begin
				head[i] = FR;
				tail[i] = FR;
			end
			built  = 0;
			errors = 0;
		endfunction

		function void append(int o, int x);
			int t;
			if (o >= ORD || x >= FR) return;
			t = tail[o];
			prv[x] = t;
			nxt[x] = FR;
			if (t >= FR) head[o] = x;
			else nxt[t] = x;
			tail[o] = x;
		endfunction

		function void unlink(int o, int x);
			int p;
			int n;
			if (o >= ORD || x >= FR) return;
			p = prv[x];
			n = nxt[x];
			if (p >= FR) head[o] = n;
			else nxt[p] = n;
			if (n >= FR) tail[o] = p;
			else prv[n] = p;
		endfunction

		// Joins the free block at f with its buddy; gives the lower head, or -1.
		function int merge_up(int f, bit linked);
			int t;
			int b;
			int lo;
			int hi;
			if (f >= FR) return -1;
			t = tag[f];
			if (t >= ORD - 1) return -1;
			b  = f ^ (1 << t);
			lo = (f < b) ? f : b;
			hi = (f < b) ? b : f;
			if (hi >= FR || tag[lo] != tag[hi]) return -1;
			tag[lo] = 5'(t + 1);
			tag[hi] = bfa_pkg::TAG_GROUPED;
			if (linked) begin
				unlink(t, lo);
				unlink(t, hi);
				append(t + 1, lo);
			end
			return lo;
		endfunction

		function void note_request(bfa_pkg::op_t o, int f, int l, int ord);
			outcome_t r;
			int       k;
			int       x;
			int       y;
			int       b;
			int       n;
			r.st = bfa_pkg::ST_OK;
			r.fr = '0;
			case (o)
				bfa_pkg::OP_RESERVE: begin
					if (built) r.st = bfa_pkg::ST_WRONG_PHASE;
					else if (f >= FR || l >= FR) r.st = bfa_pkg::ST_RANGE;
					else for (int i = f; i <= l; i++) tag[i] = bfa_pkg::TAG_RESERVED;
				end
				bfa_pkg::OP_BUILD: begin
					if (built) r.st = bfa_pkg::ST_WRONG_PHASE;
					else begin
						for (int lv = 0; lv < ORD; lv++)
							for (int i = 0; i < FR; i += (2 << lv))
								void'(merge_up(i, 0));
						for (int i = 0; i < FR; i++)
							if (tag[i] < ORD) append(tag[i], i);
						built = 1;
					end
				end
				bfa_pkg::OP_ALLOC: begin
					if (!built) r.st = bfa_pkg::ST_WRONG_PHASE;
					else if (ord >= ORD) r.st = bfa_pkg::ST_RANGE;
					else begin
						k = ord;
						while (k < ORD && head[k] >= FR) k++;
						if (k >= ORD) r.st = bfa_pkg::ST_NO_BLOCK;
						else begin
							x = head[k];
							unlink(k, x);
							tag[x] = bfa_pkg::TAG_ALLOCATED;
							// Upper halves of each split go back to the lower lists.
							while (k > ord) begin
								k--;
								b = x ^ (1 << k);
								if (b < FR) begin
									tag[b] = 5'(k);
									append(k, b);
								end
							end
							r.fr = 16'(x);
							live.push_back(r.fr);
						end
					end
				end
				default: begin
					if (!built) r.st = bfa_pkg::ST_WRONG_PHASE;
					else if (f >= FR) r.st = bfa_pkg::ST_RANGE;
					else if (tag[f] != bfa_pkg::TAG_ALLOCATED) r.st = bfa_pkg::ST_NOT_ALLOC;
					else begin
						// The order of the block follows from the grouped marks.
						x = f;
						y = f;
						k = 0;
						b = y ^ 1;
						while (k < ORD - 1 && b < FR && tag[b] == bfa_pkg::TAG_GROUPED) begin
							if (y > b) y = b;
							k++;
							b = y ^ (1 << k);
						end
						tag[x] = 5'(k);
						append(k, x);
						n = merge_up(x, 1);
						while (n >= 0) begin
							x = n;
							n = merge_up(x, 1);
						end
						foreach (live[i])
							if (live[i] == 16'(f)) begin
								live.delete(i);
								break;
							end
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [15:0] fr);
			outcome_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d frame %0d",
					$time, st, fr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$display("%0t: status mismatch: expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (fr !== e.fr) begin
				$display("%0t: frame mismatch: expected %0d actual %0d", $time, e.fr, fr);
				errors++;
			end
		endfunction
	endclass

	alloc_scoreboard sb = new();

	buddy_frame_allocator #(
		.FRAMES(FR),
		.ORDERS(ORD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.first_frame(first_frame),
		.last_frame(last_frame),
		.order(order),
		.done(done),
		.status(status),
		.frame(frame)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// A result strobed at the same edge as a new request belongs to an older
	// request, so it is checked before the new request is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(status, frame);
			if (start && !busy)
				sb.note_request(bfa_pkg::op_t'(op), first_frame, last_frame, order);
		end
	end

	// Drives one request at a falling edge and holds it until it is taken.
	task automatic send_request(bfa_pkg::op_t o, int f, int l, int ord);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start       = 1'b1;
		op          = o;
		first_frame = 16'(f);
		last_frame  = 16'(l);
		order       = 4'(ord);
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Returns every handed-out block, which exercises the long merge chains.
	task automatic free_all();
		while (sb.live.size() > 0)
			send_request(bfa_pkg::OP_FREE, sb.live[$urandom_range(sb.live.size() - 1)], 0, 0);
	endtask

	task automatic random_request();
		int r;
		int s;
		r = $urandom_range(99);
		if (r < 45) begin
			s = $urandom_range(99);
			if (s < 80) send_request(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom_range(3));
			else if (s < 95) send_request(bfa_pkg::OP_ALLOC, 0, 0, $urandom_range(10, 4));
			else send_request(bfa_pkg::OP_ALLOC, 0, 0, $urandom_range(15, 11));
		end else if (r < 85 && sb.live.size() > 0) begin
			send_request(bfa_pkg::OP_FREE, sb.live[$urandom_range(sb.live.size() - 1)], 0, 0);
		end else begin
			case ($urandom_range(4))
				0: send_request(bfa_pkg::OP_FREE, $urandom_range(65535), 0, 0);
				1: send_request(bfa_pkg::OP_FREE, $urandom_range(FR - 1), 0, 0);
				2: send_request(bfa_pkg::OP_RESERVE, $urandom_range(65535),
					$urandom_range(65535), 0);
				3: send_request(bfa_pkg::OP_BUILD, $urandom_range(65535), 0,
					$urandom_range(15));
				default: send_request(bfa_pkg::OP_ALLOC, 0, 0, $urandom_range(15));
			endcase
		end
	endtask

	initial begin
		int phase_pct[4] = '{0, 54, 10, 0};
		arst_n      = 1'b0;
		start       = 1'b0;
		op          = bfa_pkg::OP_RESERVE;
		first_frame = '0;
		last_frame  = '0;
		order       = '0;
		idle_pct    = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: wrong phase before build, reserve errors, a reversed
		// range, reserves at both ends, build twice, and allocate/free errors.
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 0);
		send_request(bfa_pkg::OP_FREE, 0, 0, 0);
		send_request(bfa_pkg::OP_RESERVE, 65535, 0, 0);
		send_request(bfa_pkg::OP_RESERVE, 5, 65535, 0);
		send_request(bfa_pkg::OP_RESERVE, 1024, 1024, 0);
		send_request(bfa_pkg::OP_RESERVE, 20, 10, 0);
		send_request(bfa_pkg::OP_RESERVE, 0, 0, 0);
		send_request(bfa_pkg::OP_RESERVE, 37, 70, 0);
		send_request(bfa_pkg::OP_RESERVE, 1023, 1023, 0);
		for (int i = 0; i < 3; i++) begin
			int a;
			a = $urandom_range(FR - 1);
			send_request(bfa_pkg::OP_RESERVE, a,
				a + $urandom_range(3) < FR ? a + $urandom_range(3) : a, 0);
		end
		send_request(bfa_pkg::OP_BUILD, 0, 0, 0);
		send_request(bfa_pkg::OP_BUILD, 0, 0, 0);
		send_request(bfa_pkg::OP_RESERVE, 100, 200, 0);
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 15);
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 11);
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 10);
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 0);
		send_request(bfa_pkg::OP_ALLOC, 0, 0, 9);
		send_request(bfa_pkg::OP_FREE, 65535, 0, 0);
		send_request(bfa_pkg::OP_FREE, 1024, 0, 0);
		send_request(bfa_pkg::OP_FREE, 0, 0, 0);
		send_request(bfa_pkg::OP_FREE, 1, 0, 0);
		free_all();

		// Random part in phases of differing sender gaps.
		foreach (phase_pct[p]) begin
			idle_pct = phase_pct[p];
			repeat (320) random_request();
			free_all();
		end

		start = 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("** buddy_frame_allocator: PASSED **");
		else $display("** buddy_frame_allocator: FAILED **");
		$finish;
	end

	initial begin
		#30ms;
		$display("** buddy_frame_allocator: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/bfa_pkg.sv
rtl/buddy_frame_allocator.sv
dv/tb.sv
